// ===== hw/rtl/pdvr_pkg.sv =====
package pdvr_pkg;

    localparam logic [11:0] DAC_MAX = 12'd3232;
    localparam logic signed [30:0] INTEG_LIMIT = 31'sd500000000;

    // x / 1e6 = (x >> 6) / 15625, reciprocal of 15625 scaled by 2^34
    localparam int unsigned DIV_SHIFT = 6;
    localparam logic [13:0] DIV_ODD = 14'd15625;
    localparam logic [20:0] DIV_RECIP = 21'd1099511;
    localparam int unsigned DIV_RECIP_SHIFT = 34;

    localparam logic [14:0] RST_TARGET_MV = 15'd5000;
    localparam logic [11:0] RST_BASE_STEPS = 12'd0;
    localparam logic [9:0] RST_PROP_GAIN = 10'd300;
    localparam logic [9:0] RST_INTEG_GAIN = 10'd50;
    localparam logic [14:0] RST_CURRENT_LIMIT_MA = 15'd3000;

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_ENABLE = 2'd1,
        ACT_DISABLE = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        CFG_TARGET_MV = 3'd0,
        CFG_BASE_STEPS = 3'd1,
        CFG_PROP_GAIN = 3'd2,
        CFG_INTEG_GAIN = 3'd3,
        CFG_CURRENT_LIMIT_MA = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0] action;
        logic [31:0] now_ms;
        logic [14:0] voltage_mv;
        logic signed [15:0] current_ma;
    } t_in_item;

    typedef struct packed {
        logic [11:0] dac_code;
        logic output_on;
        logic status;
    } t_out_item;

    typedef struct packed {
        logic is_sample;
        logic output_on;
        logic status;
    } t_side;

endpackage

// ===== hw/rtl/pdvr_in_if.sv =====
interface pdvr_in_if import pdvr_pkg::*; ();
    logic valid;
    logic ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/pdvr_out_if.sv =====
interface pdvr_out_if import pdvr_pkg::*; ();
    logic valid;
    logic ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/pdvr_div1m.sv =====
module pdvr_div1m import pdvr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    output logic o_rdy,
    input  logic signed [41:0] i_num,
    input  t_side i_side,
    output logic o_vld,
    input  logic i_rdy,
    output logic [20:0] o_quo,
    output logic o_neg,
    output t_side o_side
);

    typedef struct packed {
        t_side side;
        logic neg;
        logic [33:0] x;
    } t_sa;

    typedef struct packed {
        t_side side;
        logic neg;
        logic [33:0] x;
        logic [37:0] p_hi;
        logic [37:0] p_lo;
    } t_sb;

    typedef struct packed {
        t_side side;
        logic neg;
        logic [33:0] x;
        logic [20:0] q0;
    } t_sc;

    typedef struct packed {
        t_side side;
        logic neg;
        logic [20:0] q;
    } t_sd;

    logic r_va, r_vb, r_vc, r_vd;
    t_sa r_sa;
    t_sb r_sb;
    t_sc r_sc;
    t_sd r_sd;
    t_sa n_sa;
    t_sb n_sb;
    t_sc n_sc;
    t_sd n_sd;
    logic w_en_a, w_en_b, w_en_c, w_en_d;
    logic [41:0] w_mag;
    logic [54:0] w_psum;
    logic [34:0] w_qm;
    logic [34:0] w_rem;

    assign w_en_d = !r_vd || i_rdy;
    assign w_en_c = !r_vc || w_en_d;
    assign w_en_b = !r_vb || w_en_c;
    assign w_en_a = !r_va || w_en_b;
    assign o_rdy = w_en_a;

    always_comb begin
        w_mag = i_num[41] ? 42'(-i_num) : 42'(i_num);
        n_sa.side = i_side;
        n_sa.neg = i_num[41];
        n_sa.x = w_mag[39:DIV_SHIFT];

        n_sb.side = r_sa.side;
        n_sb.neg = r_sa.neg;
        n_sb.x = r_sa.x;
        n_sb.p_hi = 38'(r_sa.x[33:17]) * 38'(DIV_RECIP);
        n_sb.p_lo = 38'(r_sa.x[16:0]) * 38'(DIV_RECIP);

        w_psum = {r_sb.p_hi, 17'd0} + 55'(r_sb.p_lo);
        n_sc.side = r_sb.side;
        n_sc.neg = r_sb.neg;
        n_sc.x = r_sb.x;
        n_sc.q0 = w_psum[54:DIV_RECIP_SHIFT];

        // q0 is low by at most one
        w_qm = 35'(r_sc.q0) * 35'(DIV_ODD);
        w_rem = 35'(r_sc.x) - w_qm;
        n_sd.side = r_sc.side;
        n_sd.neg = r_sc.neg;
        n_sd.q = (w_rem >= 35'(DIV_ODD)) ? r_sc.q0 + 21'd1 : r_sc.q0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (w_en_a) r_va <= i_vld;
            if (w_en_b) r_vb <= r_va;
            if (w_en_c) r_vc <= r_vb;
            if (w_en_d) r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) r_sa <= n_sa;
        if (w_en_b) r_sb <= n_sb;
        if (w_en_c) r_sc <= n_sc;
        if (w_en_d) r_sd <= n_sd;
    end

    assign o_vld = r_vd;
    assign o_quo = r_sd.q;
    assign o_neg = r_sd.neg;
    assign o_side = r_sd.side;

endmodule

// ===== hw/rtl/pi_dac_voltage_regulator.sv =====
// PI voltage regulator producing a DAC code. One result per input transfer; a new
// item is taken every cycle while the output is not stalled. The rate is set by the
// integrator update, a combinational add and clamp on the accumulator; products and
// the divide by 1e6 are pipelined around it. No clearing pass after reset.
// Configuration writes take effect at once; the user must make them only while the
// block is idle, which the block itself does not enforce.
module pi_dac_voltage_regulator import pdvr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    pdvr_in_if.sink i_in,
    pdvr_out_if.source o_out,
    input  logic i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [14:0] i_cfg_data
);

    typedef struct packed {
        t_side side;
        logic restart;
        logic signed [15:0] err;
        logic [31:0] dt;
    } t_s0;

    typedef struct packed {
        t_side side;
        logic restart;
        logic signed [15:0] err;
        logic signed [48:0] prod;
    } t_s1;

    typedef struct packed {
        t_side side;
        logic signed [15:0] err;
        logic signed [30:0] integ;
    } t_s2;

    typedef struct packed {
        t_side side;
        logic signed [26:0] pe;
        logic signed [41:0] ie;
    } t_s3;

    typedef struct packed {
        t_side side;
        logic signed [41:0] num;
    } t_s4;

    logic [14:0] r_target_mv;
    logic [11:0] r_base_steps;
    logic [9:0] r_prop_gain;
    logic [9:0] r_integ_gain;
    logic [14:0] r_current_limit_ma;

    logic signed [30:0] r_acc;
    logic [31:0] r_last_tick;
    logic r_switch;
    logic [11:0] r_last_code;

    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_out_vld;
    t_s0 r_s0;
    t_s1 r_s1;
    t_s2 r_s2;
    t_s3 r_s3;
    t_s4 r_s4;
    t_out_item r_out;
    t_s0 n_s0;
    t_s1 n_s1;
    t_s2 n_s2;
    t_s3 n_s3;
    t_s4 n_s4;
    t_out_item n_out;
    logic signed [30:0] n_acc;
    logic n_switch;
    logic n_tick_upd;

    logic w_en0, w_en1, w_en2, w_en3, w_en4, w_en_out;
    logic w_acc_in;
    logic w_trip;
    logic signed [49:0] w_sum;
    logic signed [30:0] w_clamped;
    logic w_div_rdy, w_div_vld, w_div_neg;
    logic [20:0] w_div_quo;
    t_side w_div_side;
    logic signed [22:0] w_diff;
    logic [11:0] w_code;

    assign w_en_out = !r_out_vld || o_out.ready;
    assign w_en4 = !r_v4 || w_div_rdy;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign w_en0 = !r_v0 || w_en1;
    assign i_in.ready = w_en0;
    assign w_acc_in = i_in.valid && w_en0;

    // front: error, elapsed time, trip and switch state
    always_comb begin
        w_trip = $signed({i_in.data.current_ma[15], i_in.data.current_ma}) >
                 $signed({2'b00, r_current_limit_ma});
        n_s0.side.is_sample = 1'b0;
        n_s0.side.status = 1'b0;
        n_s0.restart = 1'b0;
        n_s0.err = $signed({1'b0, r_target_mv}) - $signed({1'b0, i_in.data.voltage_mv});
        n_s0.dt = i_in.data.now_ms - r_last_tick;
        n_switch = r_switch;
        n_tick_upd = 1'b0;
        case (i_in.data.action)
            ACT_SAMPLE: begin
                n_s0.side.is_sample = 1'b1;
                n_s0.side.status = w_trip;
                n_s0.restart = w_trip;
                n_switch = w_trip ? 1'b0 : r_switch;
                n_tick_upd = 1'b1;
            end
            ACT_ENABLE: begin
                n_s0.restart = 1'b1;
                n_switch = 1'b1;
                n_tick_upd = 1'b1;
            end
            ACT_DISABLE: begin
                n_s0.restart = 1'b1;
                n_switch = 1'b0;
                n_tick_upd = 1'b1;
            end
            default: begin
            end
        endcase
        n_s0.side.output_on = n_switch;
    end

    always_comb begin
        n_s1.side = r_s0.side;
        n_s1.restart = r_s0.restart;
        n_s1.err = r_s0.err;
        n_s1.prod = r_s0.err * $signed({1'b0, r_s0.dt});

        w_sum = 50'(r_acc) + 50'(r_s1.prod);
        if (w_sum > 50'(INTEG_LIMIT)) begin
            w_clamped = INTEG_LIMIT;
        end else if (w_sum < -50'(INTEG_LIMIT)) begin
            w_clamped = -INTEG_LIMIT;
        end else begin
            w_clamped = w_sum[30:0];
        end
        if (r_s1.restart) begin
            n_acc = '0;
        end else if (r_s1.side.is_sample) begin
            n_acc = w_clamped;
        end else begin
            n_acc = r_acc;
        end
        n_s2.side = r_s1.side;
        n_s2.err = r_s1.err;
        n_s2.integ = w_clamped;

        n_s3.side = r_s2.side;
        n_s3.pe = $signed({1'b0, r_prop_gain}) * r_s2.err;
        n_s3.ie = $signed({1'b0, r_integ_gain}) * r_s2.integ;

        n_s4.side = r_s3.side;
        n_s4.num = 42'(r_s3.pe) * 42'sd1000 + r_s3.ie;
    end

    pdvr_div1m u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_v4),
        .o_rdy   (w_div_rdy),
        .i_num   (r_s4.num),
        .i_side  (r_s4.side),
        .o_vld   (w_div_vld),
        .i_rdy   (w_en_out),
        .o_quo   (w_div_quo),
        .o_neg   (w_div_neg),
        .o_side  (w_div_side)
    );

    // code = base - adj, saturated
    always_comb begin
        if (w_div_neg) begin
            w_diff = $signed({11'd0, r_base_steps}) + $signed({2'b00, w_div_quo});
        end else begin
            w_diff = $signed({11'd0, r_base_steps}) - $signed({2'b00, w_div_quo});
        end
        if (w_diff < 0) begin
            w_code = '0;
        end else if (w_diff > $signed({11'd0, DAC_MAX})) begin
            w_code = DAC_MAX;
        end else begin
            w_code = w_diff[11:0];
        end
        n_out.dac_code = w_div_side.is_sample ? w_code : r_last_code;
        n_out.output_on = w_div_side.output_on;
        n_out.status = w_div_side.status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_mv <= RST_TARGET_MV;
            r_base_steps <= RST_BASE_STEPS;
            r_prop_gain <= RST_PROP_GAIN;
            r_integ_gain <= RST_INTEG_GAIN;
            r_current_limit_ma <= RST_CURRENT_LIMIT_MA;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TARGET_MV: r_target_mv <= i_cfg_data;
                CFG_BASE_STEPS: r_base_steps <= i_cfg_data[11:0];
                CFG_PROP_GAIN: r_prop_gain <= i_cfg_data[9:0];
                CFG_INTEG_GAIN: r_integ_gain <= i_cfg_data[9:0];
                CFG_CURRENT_LIMIT_MA: r_current_limit_ma <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_out_vld <= 1'b0;
            r_acc <= '0;
            r_last_tick <= '0;
            r_switch <= 1'b0;
            r_last_code <= '0;
        end else begin
            if (w_en0) r_v0 <= i_in.valid;
            if (w_en1) r_v1 <= r_v0;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
            if (w_en_out) r_out_vld <= w_div_vld;
            if (w_acc_in) begin
                r_switch <= n_switch;
                if (n_tick_upd) r_last_tick <= i_in.data.now_ms;
            end
            if (w_en2 && r_v1) r_acc <= n_acc;
            if (w_en_out && w_div_vld && w_div_side.is_sample) r_last_code <= w_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en0) r_s0 <= n_s0;
        if (w_en1) r_s1 <= n_s1;
        if (w_en2) r_s2 <= n_s2;
        if (w_en3) r_s3 <= n_s3;
        if (w_en4) r_s4 <= n_s4;
        if (w_en_out) r_out <= n_out;
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data = r_out;

endmodule
